// ----- hdl/crc8fr_pkg.sv -----
// Shared types, constants and the CRC-8 step function of the frame receiver.
`timescale 1ns / 1ps

package crc8fr_pkg;

	// CRC-8 polynomial x^8 + x^2 + x + 1, MSB first, no reflection.
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] CRC_TOPBIT = 8'h80;

	// Register reset values.
	localparam logic [7:0] HDR_RESET = 8'hAF;
	localparam logic [7:0] MAX_RESET = 8'd32;

	// Fixed bytes per frame: header, type, length and CRC.
	localparam logic [8:0] FIXED_BYTES = 9'd4;

	// Configuration register indexes.
	localparam logic CFG_HEADER = 1'b0;
	localparam logic CFG_MAX    = 1'b1;

	// Frame status codes.
	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_CRC_ERR  = 2'd1;
	localparam logic [1:0] ST_OVERSIZE = 2'd2;

	// Parse phase.
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_TYPE    = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC     = 3'd4
	} phase_t;

	// Position in the payload, saturating after the second byte.
	typedef enum logic [1:0] {
		IDX_FIRST  = 2'd0,
		IDX_SECOND = 2'd1,
		IDX_REST   = 2'd2
	} pay_idx_t;

	// One frame report.
	typedef struct packed {
		logic [7:0] payload_len;
		logic [7:0] payload_second;
		logic [7:0] payload_first;
		logic [7:0] msg_type;
		logic [1:0] frame_status;
	} result_t;

	// One byte through the CRC register, all eight shifts unrolled.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((v & CRC_TOPBIT) != 8'd0) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ----- hdl/crc8fr_parser.sv -----
// Frame parse state machine: header hunt, field capture and CRC check.
`timescale 1ns / 1ps

module crc8fr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           header_value,
	input  logic [7:0]           max_frame_bytes,
	output logic                 res_valid,
	output crc8fr_pkg::result_t  res
);
	import crc8fr_pkg::*;

	phase_t     phase_q, phase_d;
	pay_idx_t   idx_q, idx_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] type_q, type_d;
	logic [7:0] len_q, len_d;
	logic [7:0] first_q, first_d;
	logic [7:0] second_q, second_d;
	logic [7:0] crc_next;
	logic       oversize;

	assign crc_next = crc8_update(crc_q, rx_byte);
	assign oversize = ({1'b0, rx_byte} + FIXED_BYTES) > {1'b0, max_frame_bytes};

	// Next state for one accepted word.
	always_comb begin
		phase_d     = phase_q;
		idx_d       = idx_q;
		remaining_d = remaining_q;
		crc_d       = crc_q;
		type_d      = type_q;
		len_d       = len_q;
		first_d     = first_q;
		second_d    = second_q;
		case (phase_q)
			PH_TYPE: begin
				type_d  = rx_byte;
				crc_d   = crc_next;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d = rx_byte;
				crc_d = crc_next;
				if (oversize) begin
					first_d  = 8'd0;
					second_d = 8'd0;
					phase_d  = PH_HUNT;
				end else begin
					remaining_d = rx_byte;
					idx_d       = IDX_FIRST;
					phase_d     = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				case (idx_q)
					IDX_FIRST: begin
						first_d = rx_byte;
						idx_d   = IDX_SECOND;
					end
					IDX_SECOND: begin
						second_d = rx_byte;
						idx_d    = IDX_REST;
					end
					default: begin
						idx_d = IDX_REST;
					end
				endcase
				crc_d       = crc_next;
				remaining_d = remaining_q - 8'd1;
				if (remaining_q == 8'd1) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				phase_d = PH_HUNT;
			end
			default: begin
				// Hunting; unused phase codes behave the same way.
				phase_d = PH_HUNT;
				if (rx_byte == header_value) begin
					crc_d       = crc8_update(8'd0, rx_byte);
					type_d      = 8'd0;
					len_d       = 8'd0;
					first_d     = 8'd0;
					second_d    = 8'd0;
					idx_d       = IDX_FIRST;
					remaining_d = 8'd0;
					phase_d     = PH_TYPE;
				end
			end
		endcase
	end

	// Report on the length byte of an oversize frame and on every CRC byte.
	always_comb begin
		res_valid          = 1'b0;
		res.frame_status   = ST_GOOD;
		res.msg_type       = type_q;
		res.payload_first  = first_q;
		res.payload_second = second_q;
		res.payload_len    = len_q;
		case (phase_q)
			PH_LEN: begin
				res_valid          = step && oversize;
				res.frame_status   = ST_OVERSIZE;
				res.payload_first  = 8'd0;
				res.payload_second = 8'd0;
				res.payload_len    = rx_byte;
			end
			PH_CRC: begin
				res_valid        = step;
				res.frame_status = (rx_byte == crc_q) ? ST_GOOD : ST_CRC_ERR;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			idx_q       <= IDX_FIRST;
			remaining_q <= 8'd0;
			crc_q       <= 8'd0;
			type_q      <= 8'd0;
			len_q       <= 8'd0;
			first_q     <= 8'd0;
			second_q    <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			idx_q       <= idx_d;
			remaining_q <= remaining_d;
			crc_q       <= crc_d;
			type_q      <= type_d;
			len_q       <= len_d;
			first_q     <= first_d;
			second_q    <= second_d;
		end
	end

endmodule

// ----- hdl/crc8fr_out_reg.sv -----
// Result register that holds one frame report until the sink takes it.
`timescale 1ns / 1ps

module crc8fr_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  crc8fr_pkg::result_t  res,
	output logic                 space,
	output logic                 tvalid,
	input  logic                 tready,
	output logic [39:0]          tdata
);
	import crc8fr_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Room for a new report when empty or when the held one leaves now.
	assign space  = !valid_q || tready;
	assign tvalid = valid_q;
	assign tdata  = {6'd0, res_q.payload_len, res_q.payload_second,
			res_q.payload_first, res_q.msg_type, res_q.frame_status};

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	// Report payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- hdl/crc8_frame_receiver.sv -----
// Top level of the CRC-8 checked UART frame receiver.
`timescale 1ns / 1ps

// Takes one received byte per word and reports each frame (header, type,
// length, payload, CRC-8 over all bytes before it, polynomial 0x07) once:
// good, CRC mismatch, or oversize at the length byte. A byte is taken every
// cycle while the result register has room; a report on its last byte passes
// the input register, then the result register. The rate is set by the parse
// state update, where a full eight-bit CRC step is done for each byte.
module crc8_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_wen,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata,
	// Byte stream in.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	// Frame reports out.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [1:0] frame_status, [9:2] msg_type,
	                              // [17:10] payload_first, [25:18] payload_second,
	                              // [33:26] payload_len, [39:34] zero
);
	import crc8fr_pkg::*;

	logic [7:0] header_value_q;
	logic [7:0] max_frame_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_space;
	logic       advance;
	logic       res_valid;
	result_t    res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_value_q <= HDR_RESET;
			max_frame_q    <= MAX_RESET;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_HEADER: header_value_q <= cfg_wdata;
				CFG_MAX:    max_frame_q    <= cfg_wdata;
				default:    header_value_q <= header_value_q;
			endcase
		end
	end

	// The held word moves into the parser whenever the result side has room.
	assign advance  = valid_s1 && out_space;
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	crc8fr_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.rx_byte         (byte_s1),
		.header_value    (header_value_q),
		.max_frame_bytes (max_frame_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	crc8fr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.space  (out_space),
		.tvalid (m_tvalid),
		.tready (m_tready),
		.tdata  (m_tdata)
	);

	// The parser only reports when the result register can take it.
	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> out_space)
		else $error("report produced with no room in the result register");

	// A word waiting in the input register is kept until it is parsed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("waiting input word lost or changed");

	// Only the three defined status codes are reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("undefined frame status reported");

	// Payload fields of an oversize report are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.frame_status == ST_OVERSIZE)) |->
		(res.payload_first == 8'd0 && res.payload_second == 8'd0))
		else $error("oversize report carries payload bytes");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the CRC-8 checked UART frame receiver.
`timescale 1ns / 1ps

module tb_top;
	import crc8fr_pkg::*;

	// Cycles without any accepted word before the run is declared hung.
	localparam int HANG_LIMIT = 3000;
	// Quiet cycles after the last expected report before a register write.
	localparam int SETTLE_CYCLES = 8;

	// Receiver stall behavior, chosen anew each time rx_count wraps to zero.
	typedef enum logic [1:0] {
		RX_OPEN    = 2'd0,
		RX_PATTERN = 2'd1,
		RX_RANDOM  = 2'd2,
		RX_CHOKED  = 2'd3
	} rx_mode_t;

	// Frame parser mirror and the store of reports it predicts.
	class frame_scoreboard;
		logic [7:0] hdr_byte;
		logic [7:0] max_bytes;
		phase_t     parse_phase;
		logic [7:0] bytes_left;
		logic [7:0] crc_acc;
		logic [7:0] typ_byte;
		logic [7:0] len_byte;
		logic [7:0] pay0;
		logic [7:0] pay1;
		int         pay_pos;
		result_t    expected_reports[$];
		int         errors;
		int         status_seen[3];

		function new();
			hdr_byte    = HDR_RESET;
			max_bytes   = MAX_RESET;
			parse_phase = PH_HUNT;
			bytes_left  = 8'd0;
			crc_acc     = 8'd0;
			typ_byte    = 8'd0;
			len_byte    = 8'd0;
			pay0        = 8'd0;
			pay1        = 8'd0;
			pay_pos     = 0;
			errors      = 0;
			status_seen = '{0, 0, 0};
		endfunction

		// One byte through the CRC-8 register, MSB first.
		static function logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
			logic [7:0] r;
			r = c ^ b;
			repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
			return r;
		endfunction

		function void write_reg(logic addr, logic [7:0] data);
			if (addr == CFG_HEADER) begin
				hdr_byte = data;
			end else begin
				max_bytes = data;
			end
		endfunction

		function void queue_report(logic [1:0] status);
			result_t r;
			r.frame_status   = status;
			r.msg_type       = typ_byte;
			r.payload_first  = pay0;
			r.payload_second = pay1;
			r.payload_len    = len_byte;
			expected_reports.push_back(r);
		endfunction

		// Advance the parser by one accepted byte.
		function void note_byte(logic [7:0] b);
			case (parse_phase)
				PH_TYPE: begin
					typ_byte    = b;
					crc_acc     = crc_byte(crc_acc, b);
					parse_phase = PH_LEN;
				end
				PH_LEN: begin
					len_byte = b;
					crc_acc  = crc_byte(crc_acc, b);
					if ({1'b0, b} + FIXED_BYTES > {1'b0, max_bytes}) begin
						pay0        = 8'd0;
						pay1        = 8'd0;
						parse_phase = PH_HUNT;
						queue_report(ST_OVERSIZE);
					end else begin
						bytes_left  = b;
						pay_pos     = 0;
						parse_phase = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (pay_pos == 0) begin
						pay0 = b;
					end else if (pay_pos == 1) begin
						pay1 = b;
					end
					if (pay_pos < 255) pay_pos++;
					crc_acc    = crc_byte(crc_acc, b);
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'd0) parse_phase = PH_CRC;
				end
				PH_CRC: begin
					parse_phase = PH_HUNT;
					queue_report((b == crc_acc) ? ST_GOOD : ST_CRC_ERR);
				end
				default: begin
					parse_phase = PH_HUNT;
					if (b == hdr_byte) begin
						crc_acc     = crc_byte(8'd0, b);
						typ_byte    = 8'd0;
						len_byte    = 8'd0;
						pay0        = 8'd0;
						pay1        = 8'd0;
						pay_pos     = 0;
						bytes_left  = 8'd0;
						parse_phase = PH_TYPE;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("report field %s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		// Check one accepted report word against the oldest expectation.
		function void check_report(logic [39:0] w);
			result_t want;
			result_t got;
			if (expected_reports.size() == 0) begin
				$error("report 0x%010h arrived with none expected", w);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			got  = w[33:0];
			compare_field("frame_status", want.frame_status, got.frame_status);
			compare_field("msg_type", want.msg_type, got.msg_type);
			compare_field("payload_first", want.payload_first, got.payload_first);
			compare_field("payload_second", want.payload_second, got.payload_second);
			compare_field("payload_len", want.payload_len, got.payload_len);
			compare_field("padding", 0, w[39:34]);
			if (want.frame_status <= ST_OVERSIZE) status_seen[want.frame_status]++;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic        cfg_addr  = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;

	frame_scoreboard sb;
	logic [7:0]  tx_bytes[$];
	logic [7:0]  cur_hdr = HDR_RESET;
	logic [7:0]  cur_max = MAX_RESET;
	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;
	logic [7:0]  in_word = 8'd0;
	logic [39:0] out_word = 40'd0;
	int          idle_cycles = 0;
	int          bytes_taken = 0;
	int          settings_used = 1;
	rx_mode_t    rx_mode = RX_OPEN;
	logic [31:0] rx_bits = 32'hFFFF_FFFF;
	logic [5:0]  rx_count = 6'd0;

	crc8_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	// Sample both handshakes mid-cycle, where every signal is settled.
	always @(negedge clk) begin
		in_fire  = s_tvalid & s_tready;
		out_fire = m_tvalid & m_tready;
		in_word  = s_tdata;
		out_word = m_tdata;
	end

	// Feed accepted words to the scoreboard and watch for a hang.
	always @(posedge clk) begin
		if (in_fire) begin
			sb.note_byte(in_word);
			bytes_taken++;
		end
		if (out_fire) sb.check_report(out_word);
		if (in_fire || out_fire) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= HANG_LIMIT) begin
			$display("tb_top: no word accepted for %0d cycles", HANG_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Receiver back-pressure: open, a fixed bit pattern, coin flips or mostly stalled.
	always @(posedge clk) begin
		if (rx_count == 6'd0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_bits <= $urandom | 32'h1;
		end
		rx_count <= rx_count + 6'd1;
		case (rx_mode)
			RX_OPEN: begin
				m_tready <= 1'b1;
			end
			RX_PATTERN: begin
				m_tready <= rx_bits[rx_count[4:0]];
			end
			RX_RANDOM: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			default: begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Line noise byte; it mostly steers clear of the header value.
	function automatic void push_noise();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == cur_hdr && $urandom_range(0, 9) != 0) b = b ^ 8'h01;
		tx_bytes.push_back(b);
	endfunction

	// Header, type and length; payload and CRC only when the length fits.
	function automatic void push_frame(logic [7:0] typ, logic [7:0] len, bit crc_ok);
		logic [7:0] crc;
		logic [7:0] b;
		tx_bytes.push_back(cur_hdr);
		tx_bytes.push_back(typ);
		tx_bytes.push_back(len);
		crc = frame_scoreboard::crc_byte(8'd0, cur_hdr);
		crc = frame_scoreboard::crc_byte(crc, typ);
		crc = frame_scoreboard::crc_byte(crc, len);
		if ({1'b0, len} + FIXED_BYTES > {1'b0, cur_max}) return;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			tx_bytes.push_back(b);
			crc = frame_scoreboard::crc_byte(crc, b);
		end
		tx_bytes.push_back(crc_ok ? crc : (crc ^ (8'd1 << $urandom_range(0, 7))));
	endfunction

	// Mostly well-formed frames with random content, plus noise and cut-off frames.
	function automatic void gen_traffic(int budget);
		int target;
		int pick;
		int lo;
		logic [7:0] len;
		target = tx_bytes.size() + budget;
		while (tx_bytes.size() < target) begin
			repeat ($urandom_range(0, 2)) push_noise();
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				tx_bytes.push_back(cur_hdr);
				repeat ($urandom_range(1, 3)) push_noise();
				continue;
			end
			pick = $urandom_range(0, 99);
			lo = int'(cur_max) - 3;
			if (lo < 0) lo = 0;
			if (pick < 55) begin
				len = 8'($urandom_range(0, 3));
			end else if (pick < 75) begin
				len = 8'($urandom_range(4, 12));
			end else if (pick < 85) begin
				len = (cur_max >= 4 && cur_max <= 64) ? cur_max - 8'd4 : 8'($urandom_range(0, 3));
			end else if (pick < 95) begin
				len = 8'($urandom_range(lo, 255));
			end else begin
				len = 8'($urandom_range(0, 255));
			end
			push_frame(8'($urandom), len, $urandom_range(0, 3) != 0);
		end
	endfunction

	// Send the queued bytes in bursts separated by random gaps.
	task automatic send_stream();
		int idx;
		int burst_left;
		int gap_left;
		idx = 0;
		burst_left = $urandom_range(1, 40);
		gap_left = 0;
		while (idx < tx_bytes.size()) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= tx_bytes[idx];
			end
			@(posedge clk);
			if (in_fire) begin
				idx++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
					if ($urandom_range(0, 19) == 0) gap_left = 20;
				end
			end
		end
		s_tvalid <= 1'b0;
		tx_bytes.delete();
	endtask

	// Wait until the last byte is noted, then for every predicted report,
	// then let the pipeline settle.
	task automatic drain();
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(logic [7:0] hdr, logic [7:0] max_len);
		cfg_wen   <= 1'b1;
		cfg_addr  <= CFG_HEADER;
		cfg_wdata <= hdr;
		@(posedge clk);
		sb.write_reg(CFG_HEADER, hdr);
		cfg_addr  <= CFG_MAX;
		cfg_wdata <= max_len;
		@(posedge clk);
		sb.write_reg(CFG_MAX, max_len);
		cfg_wen <= 1'b0;
		@(posedge clk);
		cur_hdr = hdr;
		cur_max = max_len;
		settings_used++;
	endtask

	initial begin
		logic [7:0] hdr_list[6];
		logic [7:0] max_list[6];
		sb = new();
		hdr_list = '{8'h00, 8'hFF, HDR_RESET, 8'($urandom), 8'($urandom), HDR_RESET};
		max_list = '{8'd4, 8'd255, 8'd0, 8'($urandom_range(5, 40)),
			8'($urandom_range(4, 12)), MAX_RESET};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at reset settings: noise extremes, an empty good frame,
		// a CRC mismatch, oversize just past the limit, a header-valued type
		// byte, and the largest length byte.
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		push_frame(8'h00, 8'd0, 1'b1);
		push_frame(8'hFF, 8'd2, 1'b0);
		push_frame(8'h12, 8'd29, 1'b1);
		push_frame(HDR_RESET, 8'd1, 1'b1);
		push_frame(8'h7E, 8'd255, 1'b1);
		gen_traffic(150);
		send_stream();
		drain();

		// Six register settings, including the smallest and the largest limits.
		for (int p = 0; p < 6; p++) begin
			apply_settings(hdr_list[p], max_list[p]);
			gen_traffic(175);
			send_stream();
			drain();
		end

		$display("tb_top: %0d bytes over %0d register settings, %0d frame reports",
			bytes_taken, settings_used,
			sb.status_seen[0] + sb.status_seen[1] + sb.status_seen[2]);
		$display("tb_top: reports by status: %0d good, %0d CRC mismatch, %0d oversize",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/crc8fr_pkg.sv
hdl/crc8fr_parser.sv
hdl/crc8fr_out_reg.sv
hdl/crc8_frame_receiver.sv
bench/tb_top.sv
